@@ hdl/htb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_pkg
// Shared types and constants of the huffman tree builder.
// ----------------------------------------------------------------------------
package htb_pkg;

  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 38;
  localparam int ID_W     = 7;
  localparam int KIND_W   = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_INTERNAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LONE_LEAF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PICK_A,
    ST_PICK_B
  } htb_state_t;

endpackage

@@ hdl/htb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_if
// Valid/ready channels for leaf requests and tree node results.
// ----------------------------------------------------------------------------
interface htb_in_if import htb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol;
  logic [WEIGHT_W-1:0] weight;
  logic                last;

  modport source (output valid, output symbol, output weight, output last, input ready);
  modport sink   (input valid, input symbol, input weight, input last, output ready);
endinterface

interface htb_out_if import htb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   node_id;
  logic [ID_W-1:0]   left_id;
  logic [ID_W-1:0]   right_id;
  logic [SYM_W-1:0]  left_symbol;
  logic [SYM_W-1:0]  right_symbol;
  logic [SUM_W-1:0]  sum_weight;
  logic [KIND_W-1:0] kind;
  logic              is_last;

  modport source (output valid, output node_id, output left_id, output right_id,
                  output left_symbol, output right_symbol, output sum_weight,
                  output kind, output is_last, input ready);
  modport sink   (input valid, input node_id, input left_id, input right_id,
                  input left_symbol, input right_symbol, input sum_weight,
                  input kind, input is_last, output ready);
endinterface

@@ hdl/huffman_tree_builder_unit.sv @@
`timescale 1ns / 1ps
// an error or lone-leaf result is registered in the cycle after the last
// request is accepted
// build: each merge steps through ST_PICK_A and ST_PICK_B, one for each of the two
// registered queue-head reads per merge; ST_PICK_B waits for a free output register
// reset clears all counters, flags and the output valid; the output payload and
// the leaf and merge memories are not cleared
// ----------------------------------------------------------------------------
// huffman_tree_builder_unit
// Two-queue huffman tree construction over sorted leaves held in memory.
// ----------------------------------------------------------------------------
module huffman_tree_builder_unit import htb_pkg::*; #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic      clk,
  input  logic      rst,
  htb_in_if.sink    leaf_in,
  htb_out_if.source node_out
);

  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int AW    = $clog2(MAX_SYMBOLS);
  localparam int IDX_W = CW + ID_W + 1;
  localparam int LW    = SYM_W + WEIGHT_W;

  htb_state_t state, state_next;

  logic [CW-1:0]       leaf_count, leaf_count_next;
  logic [CW-1:0]       leaf_head, leaf_head_next;
  logic [AW-1:0]       merge_head, merge_head_next;
  logic [AW-1:0]       merge_tail;
  logic [WEIGHT_W-1:0] previous_weight;
  logic                input_fault;

  logic [ID_W-1:0]  a_id;
  logic [SYM_W-1:0] a_sym;
  logic [SUM_W-1:0] a_w;

  logic             fwd_valid;
  logic [SUM_W-1:0] fwd_data;

  logic              out_valid;
  logic [ID_W-1:0]   out_node_id, out_left_id, out_right_id;
  logic [SYM_W-1:0]  out_left_symbol, out_right_symbol;
  logic [SUM_W-1:0]  out_sum;
  logic [KIND_W-1:0] out_kind;
  logic              out_is_last;

  // control
  logic in_ready, pick_a, pick_b, out_free, accept, drop, fault_now, build, done;
  logic [CW-1:0] count_new;

  // memories
  logic [LW-1:0]    leaf_rd;
  logic [SUM_W-1:0] merge_rd;
  logic             merge_we;

  // pick datapath
  logic             have_leaf, have_merge, use_leaf;
  logic [SUM_W-1:0] leaf_w, merge_w, pick_w;
  logic [ID_W-1:0]  pick_id;
  logic [SYM_W-1:0] pick_sym;
  logic [IDX_W-1:0] leaf_id_wide, merge_id_wide, node_id_wide;
  logic [SUM_W:0]   sum_raw;
  logic [SUM_W-1:0] sum_sat;

  assign out_free = !out_valid || node_out.ready;
  assign accept   = leaf_in.valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && leaf_in.last && build) begin
          state_next = ST_PICK_A;
        end
      end
      ST_PICK_A: state_next = ST_PICK_B;
      ST_PICK_B: begin
        if (out_free) begin
          state_next = done ? ST_LOAD : ST_PICK_A;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    pick_a   = 1'b0;
    pick_b   = 1'b0;
    case (state)
      ST_LOAD:   in_ready = out_free;
      ST_PICK_A: pick_a   = 1'b1;
      ST_PICK_B: pick_b   = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // leaf loading
  assign drop      = (leaf_count >= CW'(MAX_SYMBOLS)) || (leaf_in.weight < previous_weight);
  assign count_new = leaf_count + CW'(!drop);
  assign fault_now = input_fault || drop;
  assign build     = !fault_now && (count_new != CW'(1));

  // queue heads
  assign have_leaf  = leaf_head < leaf_count;
  assign have_merge = merge_head < merge_tail;
  assign leaf_w     = {{(SUM_W-WEIGHT_W){1'b0}}, leaf_rd[WEIGHT_W-1:0]};
  assign merge_w    = fwd_valid ? fwd_data : merge_rd;
  assign use_leaf   = have_leaf && (!have_merge || (leaf_w <= merge_w));

  assign leaf_id_wide  = IDX_W'(leaf_head);
  assign merge_id_wide = IDX_W'(leaf_count) + IDX_W'(merge_head);
  assign node_id_wide  = IDX_W'(leaf_count) + IDX_W'(merge_tail);

  assign pick_id  = use_leaf ? leaf_id_wide[ID_W-1:0] : merge_id_wide[ID_W-1:0];
  assign pick_sym = use_leaf ? leaf_rd[LW-1:WEIGHT_W] : '0;
  assign pick_w   = use_leaf ? leaf_w : merge_w;

  assign sum_raw = {1'b0, a_w} + {1'b0, pick_w};
  assign sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

  // one merge leaves a single item once leaf_count - 1 merges exist
  assign done = (CW'(merge_tail) + CW'(2)) == leaf_count;

  always_comb begin
    leaf_head_next  = leaf_head;
    merge_head_next = merge_head;
    if (pick_a || pick_b) begin
      if (use_leaf) begin
        leaf_head_next = leaf_head + CW'(1);
      end else begin
        merge_head_next = merge_head + AW'(1);
      end
    end
  end

  assign leaf_count_next = count_new;
  assign merge_we        = pick_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count      <= '0;
      leaf_head       <= '0;
      merge_head      <= '0;
      merge_tail      <= '0;
      previous_weight <= '0;
      input_fault     <= 1'b0;
      fwd_valid       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      fwd_valid <= merge_we && (merge_head_next == merge_tail);
      if (node_out.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (leaf_in.last && !build) begin
          out_valid       <= 1'b1;
          leaf_count      <= '0;
          previous_weight <= '0;
          input_fault     <= 1'b0;
        end else begin
          leaf_count  <= leaf_count_next;
          input_fault <= fault_now;
          if (!drop) begin
            previous_weight <= leaf_in.weight;
          end
        end
      end
      if (pick_a || pick_b) begin
        leaf_head  <= leaf_head_next;
        merge_head <= merge_head_next;
      end
      if (pick_b) begin
        out_valid  <= 1'b1;
        merge_tail <= merge_tail + AW'(1);
        if (done) begin
          leaf_count      <= '0;
          leaf_head       <= '0;
          merge_head      <= '0;
          merge_tail      <= '0;
          previous_weight <= '0;
          input_fault     <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fwd_data <= sum_sat;
    if (pick_a) begin
      a_id  <= pick_id;
      a_sym <= pick_sym;
      a_w   <= pick_w;
    end
    if (accept && leaf_in.last && !build) begin
      out_node_id      <= '0;
      out_left_id      <= '0;
      out_right_id     <= '0;
      out_right_symbol <= '0;
      out_is_last      <= 1'b1;
      if (fault_now) begin
        out_left_symbol <= '0;
        out_sum         <= '0;
        out_kind        <= KIND_ERROR;
      end else begin
        out_left_symbol <= leaf_in.symbol;
        out_sum         <= {{(SUM_W-WEIGHT_W){1'b0}}, leaf_in.weight};
        out_kind        <= KIND_LONE_LEAF;
      end
    end
    if (pick_b) begin
      out_node_id      <= node_id_wide[ID_W-1:0];
      out_left_id      <= a_id;
      out_right_id     <= pick_id;
      out_left_symbol  <= a_sym;
      out_right_symbol <= pick_sym;
      out_sum          <= sum_sat;
      out_kind         <= KIND_INTERNAL;
      out_is_last      <= done;
    end
  end

  htb_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SYMBOLS)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (accept && !drop),
    .waddr (leaf_count[AW-1:0]),
    .wdata ({leaf_in.symbol, leaf_in.weight}),
    .raddr (leaf_head_next[AW-1:0]),
    .rdata (leaf_rd)
  );

  // a read of the entry written in the same cycle is served from fwd_data
  htb_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_merge_ram (
    .clk   (clk),
    .we    (merge_we),
    .waddr (merge_tail),
    .wdata (sum_sat),
    .raddr (merge_head_next),
    .rdata (merge_rd)
  );

  assign leaf_in.ready         = in_ready;
  assign node_out.valid        = out_valid;
  assign node_out.node_id      = out_node_id;
  assign node_out.left_id      = out_left_id;
  assign node_out.right_id     = out_right_id;
  assign node_out.left_symbol  = out_left_symbol;
  assign node_out.right_symbol = out_right_symbol;
  assign node_out.sum_weight   = out_sum;
  assign node_out.kind         = out_kind;
  assign node_out.is_last      = out_is_last;

endmodule

@@ hdl/htb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module htb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sorted leaf requests into huffman_tree_builder_unit and checks every
// node result against a two-queue tree predictor. The stimulus covers lone
// leaves, ties, unsorted and oversized sets, and full 64-leaf builds, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import htb_pkg::*;

  localparam int MAX_LEAVES    = 64;
  localparam int LEAF_TARGET   = 450;
  localparam int HANG_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_LEAF  = 320;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [ID_W-1:0]   left_id;
    logic [ID_W-1:0]   right_id;
    logic [SYM_W-1:0]  left_symbol;
    logic [SYM_W-1:0]  right_symbol;
    logic [SUM_W-1:0]  sum_weight;
    logic [KIND_W-1:0] kind;
    logic              is_last;
  } node_t;

  class tree_scoreboard;
    logic [WEIGHT_W-1:0] leaf_weight [MAX_LEAVES];
    logic [SYM_W-1:0]    leaf_symbol [MAX_LEAVES];
    logic [SUM_W-1:0]    merge_weight [MAX_LEAVES];
    int unsigned         n_leaves;
    int unsigned         leaf_ptr;
    int unsigned         merge_ptr;
    int unsigned         merge_cnt;
    logic [WEIGHT_W-1:0] prev_weight;
    bit                  bad_set;
    node_t               expected_nodes [$];
    int unsigned         errors;

    function new();
      start_over();
      errors = 0;
    endfunction

    function void start_over();
      n_leaves    = 0;
      leaf_ptr    = 0;
      merge_ptr   = 0;
      merge_cnt   = 0;
      prev_weight = '0;
      bad_set     = 1'b0;
    endfunction

    function void queue_node(node_t nd);
      expected_nodes = {expected_nodes, nd};
    endfunction

    // smallest head of the two queues, leaf queue wins a tie
    function void pop_smallest(output int unsigned id, output logic [SYM_W-1:0] sym,
                               output logic [SUM_W-1:0] w);
      bit from_leaf;
      if (leaf_ptr < n_leaves && merge_ptr < merge_cnt) begin
        from_leaf = SUM_W'(leaf_weight[leaf_ptr]) <= merge_weight[merge_ptr];
      end else begin
        from_leaf = leaf_ptr < n_leaves;
      end
      if (from_leaf) begin
        id  = leaf_ptr;
        sym = leaf_symbol[leaf_ptr];
        w   = SUM_W'(leaf_weight[leaf_ptr]);
        leaf_ptr++;
      end else begin
        id  = n_leaves + merge_ptr;
        sym = '0;
        w   = merge_weight[merge_ptr];
        merge_ptr++;
      end
    endfunction

    function void note_leaf(logic [SYM_W-1:0] sym, logic [WEIGHT_W-1:0] w, logic last);
      node_t             nd;
      int unsigned       id_a;
      int unsigned       id_b;
      logic [SYM_W-1:0]  sym_a;
      logic [SYM_W-1:0]  sym_b;
      logic [SUM_W-1:0]  w_a;
      logic [SUM_W-1:0]  w_b;
      logic [SUM_W:0]    total;
      if (n_leaves >= MAX_LEAVES || w < prev_weight) begin
        bad_set = 1'b1;
      end else begin
        leaf_weight[n_leaves] = w;
        leaf_symbol[n_leaves] = sym;
        n_leaves++;
        prev_weight = w;
      end
      if (!last) return;

      nd = '0;
      nd.is_last = 1'b1;
      if (bad_set || n_leaves == 0) begin
        nd.kind = KIND_ERROR;
        queue_node(nd);
      end else if (n_leaves == 1) begin
        nd.kind        = KIND_LONE_LEAF;
        nd.left_symbol = leaf_symbol[0];
        nd.sum_weight  = SUM_W'(leaf_weight[0]);
        queue_node(nd);
      end else begin
        while ((n_leaves - leaf_ptr) + (merge_cnt - merge_ptr) > 1) begin
          pop_smallest(id_a, sym_a, w_a);
          pop_smallest(id_b, sym_b, w_b);
          total = {1'b0, w_a} + {1'b0, w_b};
          nd.node_id  = ID_W'(n_leaves + merge_cnt);
          nd.left_id  = ID_W'(id_a);
          nd.right_id = ID_W'(id_b);
          // merged children carry no symbol
          nd.left_symbol  = (id_a < n_leaves) ? sym_a : '0;
          nd.right_symbol = (id_b < n_leaves) ? sym_b : '0;
          nd.sum_weight   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
          nd.kind         = KIND_INTERNAL;
          merge_weight[merge_cnt] = nd.sum_weight;
          merge_cnt++;
          nd.is_last = (n_leaves - leaf_ptr) + (merge_cnt - merge_ptr) <= 1;
          queue_node(nd);
        end
      end
      start_over();
    endfunction

    function void compare_field(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_node(node_t got);
      node_t want;
      if (expected_nodes.size() == 0) begin
        errors++;
        $display("%0t: unexpected node result, expected none, actual %0h", $time, got);
        return;
      end
      want = expected_nodes.pop_front();
      compare_field("node_id", SUM_W'(want.node_id), SUM_W'(got.node_id));
      compare_field("left_id", SUM_W'(want.left_id), SUM_W'(got.left_id));
      compare_field("right_id", SUM_W'(want.right_id), SUM_W'(got.right_id));
      compare_field("left_symbol", SUM_W'(want.left_symbol), SUM_W'(got.left_symbol));
      compare_field("right_symbol", SUM_W'(want.right_symbol), SUM_W'(got.right_symbol));
      compare_field("sum_weight", want.sum_weight, got.sum_weight);
      compare_field("kind", SUM_W'(want.kind), SUM_W'(got.kind));
      compare_field("is_last", SUM_W'(want.is_last), SUM_W'(got.is_last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  htb_in_if  leaf_in ();
  htb_out_if node_out ();

  tree_scoreboard sb = new();

  int unsigned leaves_sent  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  huffman_tree_builder_unit #(
    .MAX_SYMBOLS(MAX_LEAVES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .leaf_in  (leaf_in),
    .node_out (node_out)
  );

  always #5 clk = ~clk;

  // idle shares per phase: receiver slow first, then sender slow, then full rate
  function automatic int unsigned sender_idle_pct();
    return (leaves_sent < 150) ? 17 : (leaves_sent < 300) ? 69 : 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    return (leaves_sent < 150) ? 69 : (leaves_sent < 300) ? 17 : 0;
  endfunction

  task automatic send_leaf(logic [SYM_W-1:0] sym, logic [WEIGHT_W-1:0] w, logic last);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      leaf_in.valid <= 1'b0;
      @(posedge clk);
    end
    leaf_in.valid  <= 1'b1;
    leaf_in.symbol <= sym;
    leaf_in.weight <= w;
    leaf_in.last   <= last;
    @(posedge clk);
    while (!leaf_in.ready) @(posedge clk);
    sb.note_leaf(sym, w, last);
    leaves_sent++;
  endtask

  // one set of leaves, nondecreasing unless bad_at names a request that drops
  task automatic send_set(int unsigned count, logic [WEIGHT_W-1:0] start,
                          int unsigned step_max, int bad_at);
    logic [WEIGHT_W:0]   w;
    logic [WEIGHT_W-1:0] prev;
    logic [WEIGHT_W-1:0] sent_w;
    w = {1'b0, start};
    for (int i = 0; i < count; i++) begin
      prev = w[WEIGHT_W-1:0];
      if (i > 0) begin
        w = w + $urandom_range(0, step_max);
        if (w[WEIGHT_W]) w = {1'b0, {WEIGHT_W{1'b1}}};
      end
      sent_w = w[WEIGHT_W-1:0];
      if (i == bad_at) sent_w = $urandom_range(0, prev - 1);
      send_leaf(SYM_W'($urandom()), sent_w, i == count - 1);
    end
  endtask

  task automatic run_random_sets();
    int unsigned set_no;
    int unsigned count;
    int unsigned step_max;
    int          bad_at;
    logic [WEIGHT_W-1:0] start;
    set_no = 0;
    while (leaves_sent < LEAF_TARGET) begin
      case ($urandom_range(0, 3))
        0: step_max = 0;
        1: step_max = 3;
        2: step_max = 1000;
        default: step_max = 32'h00FF_FFFF;
      endcase
      case ($urandom_range(0, 2))
        0: start = '0;
        1: start = $urandom_range(1, 100);
        default: start = $urandom();
      endcase
      bad_at = -1;
      if (set_no == 4) begin
        count = MAX_LEAVES;
      end else if (set_no == 12) begin
        count = MAX_LEAVES + 1;
      end else begin
        case ($urandom_range(0, 19))
          0: count = 1;
          1, 2: begin
            count  = $urandom_range(2, 8);
            bad_at = $urandom_range(1, count - 1);
            if (start == 0) start = 1;
          end
          default: count = $urandom_range(2, 12);
        endcase
      end
      send_set(count, start, step_max, bad_at);
      set_no++;
    end
  endtask

  initial begin
    leaf_in.valid  = 1'b0;
    leaf_in.symbol = '0;
    leaf_in.weight = '0;
    leaf_in.last   = 1'b0;
    node_out.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone leaves at both extremes
    send_leaf(8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_leaf(8'h00, 32'h0000_0000, 1'b1);
    // two zero weights
    send_leaf(8'h00, 32'h0, 1'b0);
    send_leaf(8'hFF, 32'h0, 1'b1);
    // merged node ties a leaf, leaf goes first
    send_leaf(8'h01, 32'd1, 1'b0);
    send_leaf(8'h02, 32'd1, 1'b0);
    send_leaf(8'h03, 32'd2, 1'b1);
    // unsorted in the middle
    send_leaf(8'h10, 32'd5, 1'b0);
    send_leaf(8'h11, 32'd3, 1'b0);
    send_leaf(8'h12, 32'd7, 1'b1);
    // unsorted on the last request
    send_leaf(8'h20, 32'd4, 1'b0);
    send_leaf(8'h21, 32'd2, 1'b1);
    // largest weights, sums go past 32 bits
    for (int i = 0; i < 4; i++) send_leaf(SYM_W'(8'hA0 + i), 32'hFFFF_FFFF, i == 3);
    // doubling weights chain merged nodes as children
    for (int i = 0; i < 6; i++) send_leaf(SYM_W'(8'h50 + i), 32'd1 << i, i == 5);

    run_random_sets();
    leaf_in.valid <= 1'b0;

    while (sb.expected_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_nodes.size() == 0) begin
      $display("PASS huffman_tree_builder_unit");
    end else begin
      $display("FAIL huffman_tree_builder_unit");
    end
    $finish;
  end

  // result side: check, then pick next ready; one long hold-off fills the block
  always @(posedge clk) begin
    if (!rst) begin
      if (node_out.valid && node_out.ready) begin
        sb.check_node({node_out.node_id, node_out.left_id, node_out.right_id,
                       node_out.left_symbol, node_out.right_symbol,
                       node_out.sum_weight, node_out.kind, node_out.is_last});
      end
      if (!hold_done && leaves_sent >= HOLD_AT_LEAF) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        node_out.ready <= 1'b0;
      end else begin
        node_out.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    if ((leaf_in.valid && leaf_in.ready) || (node_out.valid && node_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("FAIL huffman_tree_builder_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ files.f @@
hdl/htb_pkg.sv
hdl/htb_if.sv
hdl/htb_ram.sv
hdl/huffman_tree_builder_unit.sv
test/testbench.sv
